/* src/reverse_sequence_address_gen_core_assert.svh */
// ----------------------------------------------------------------------------
// reverse_sequence_address_gen_core_assert
// Assertion macros shared by the address generator modules.
// ----------------------------------------------------------------------------
`ifndef REVERSE_SEQUENCE_ADDRESS_GEN_CORE_ASSERT_SVH
`define REVERSE_SEQUENCE_ADDRESS_GEN_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RSAG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// next-cycle implication
`define RSAG_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> nxt) else $error(msg);
`else
`define RSAG_ASSERT(lbl, clk, rst_n, prop, msg)
`define RSAG_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg)
`endif
`endif

/* src/rsag_pkg.sv */
// ----------------------------------------------------------------------------
// rsag_pkg
// Types and constants of the reverse-sequence address generator.
// ----------------------------------------------------------------------------
package rsag_pkg;

  localparam int RANK    = 4;
  localparam int BATCH   = 256;
  localparam int DIM_W   = 16;
  localparam int ADDR_W  = 32;
  localparam int BIDX_W  = $clog2(BATCH);
  localparam int AXIS_W  = $clog2(RANK);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int IN_DW   = 24;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_DIM0    = 3'd0;
  localparam logic [2:0] REG_DIM1    = 3'd1;
  localparam logic [2:0] REG_DIM2    = 3'd2;
  localparam logic [2:0] REG_DIM3    = 3'd3;
  localparam logic [2:0] REG_REV_DIM = 3'd4;
  localparam logic [2:0] REG_SEL_DIM = 3'd5;

  // request kinds carried on in_tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // tensor shape as seen by the front end (sizes already forced to >= 1)
  typedef struct packed {
    logic [RANK-1:0][DIM_W-1:0] dim;
    logic [AXIS_W-1:0]          rev_dim;
    logic [AXIS_W-1:0]          sel_dim;
  } rsag_shape_t;

  // address geometry used by the back end
  typedef struct packed {
    logic [RANK-1:0][ADDR_W-1:0] stride;
    logic [AXIS_W-1:0]           rev_dim;
  } rsag_geom_t;

  // classified item passed through the queue
  typedef struct packed {
    logic                       is_step;
    logic [RANK-1:0][DIM_W-1:0] pos;
    logic                       last;
    logic                       err;
    logic                       bidx_ok;
    logic [BIDX_W-1:0]          bidx;
    logic [DIM_W-1:0]           lval;
  } rsag_item_t;

endpackage

/* src/rsag_front.sv */
// ----------------------------------------------------------------------------
// rsag_front
// Accepts items, classifies them and owns the position counters.
// ----------------------------------------------------------------------------
module rsag_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       busy,
  input  rsag_pkg::rsag_shape_t      shape,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rsag_pkg::IN_DW-1:0] in_tdata,   // length_index, length_value
  input  logic                       in_tuser,   // req_type
  input  logic                       q_full,
  output logic                       q_push,
  output rsag_pkg::rsag_item_t       q_item
);

  logic [rsag_pkg::RANK-1:0][rsag_pkg::DIM_W-1:0] pos_r;
  logic [rsag_pkg::RANK-1:0][rsag_pkg::DIM_W-1:0] pos_nxt;
  logic [rsag_pkg::DIM_W-1:0]                     bpos;
  logic [rsag_pkg::DIM_W-1:0]                     lval;
  logic                                           is_step;
  logic                                           last;

  assign in_tready = !q_full && !busy;
  assign q_push    = in_tvalid && in_tready;
  assign is_step   = (in_tuser == rsag_pkg::REQ_STEP);
  assign lval      = in_tdata[rsag_pkg::BIDX_W +: rsag_pkg::DIM_W];
  assign bpos      = pos_r[shape.sel_dim];

  always_comb begin
    last = 1'b1;
    for (int i = 0; i < rsag_pkg::RANK; i++) begin
      if (pos_r[i] != shape.dim[i] - 16'd1) last = 1'b0;
    end
  end

  // row-major increment, innermost first
  always_comb begin
    logic carry;
    logic wrap;
    carry   = 1'b1;
    wrap    = 1'b0;
    pos_nxt = pos_r;
    for (int i = rsag_pkg::RANK - 1; i >= 0; i--) begin
      if (carry) begin
        wrap       = ({1'b0, pos_r[i]} + 17'd1) >= {1'b0, shape.dim[i]};
        pos_nxt[i] = wrap ? '0 : pos_r[i] + 16'd1;
        carry      = wrap;
      end
    end
  end

  always_comb begin
    q_item.is_step = is_step;
    q_item.pos     = pos_r;
    q_item.last    = is_step && last;
    q_item.err     = !is_step && (lval > shape.dim[shape.rev_dim]);
    q_item.bidx_ok = is_step ? (bpos[rsag_pkg::DIM_W-1:rsag_pkg::BIDX_W] == '0) : 1'b1;
    q_item.bidx    = is_step ? bpos[rsag_pkg::BIDX_W-1:0] : in_tdata[rsag_pkg::BIDX_W-1:0];
    q_item.lval    = lval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      pos_r <= '0;
    end else if (q_push && is_step) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

/* src/rsag_fifo.sv */
// ----------------------------------------------------------------------------
// rsag_fifo
// Short item queue between front and back end.
// ----------------------------------------------------------------------------
`include "reverse_sequence_address_gen_core_assert.svh"

module rsag_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rsag_pkg::rsag_item_t wr_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output rsag_pkg::rsag_item_t rd_item
);

  rsag_pkg::rsag_item_t              mem_r [rsag_pkg::QDEPTH];
  logic [rsag_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [rsag_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [rsag_pkg::QCNT_W-1:0]       count_r;

  assign full    = (count_r == rsag_pkg::QCNT_W'(rsag_pkg::QDEPTH));
  assign valid   = (count_r != '0);
  assign rd_item = mem_r[rd_ptr_r];

  // depth is a power of two: pointers wrap naturally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

  `RSAG_ASSERT(a_no_overflow, clk, rst_n, push |-> (!full || pop), "queue overflow")
  `RSAG_ASSERT(a_no_underflow, clk, rst_n, pop |-> valid, "queue underflow")
  `RSAG_ASSERT(a_count_range, clk, rst_n, count_r <= rsag_pkg::QCNT_W'(rsag_pkg::QDEPTH), "queue count out of range")

endmodule

/* src/rsag_back.sv */
// ----------------------------------------------------------------------------
// rsag_back
// Length table, sequence mirroring and address accumulation over one
// shared multiplier; holds the output register.
// ----------------------------------------------------------------------------
`include "reverse_sequence_address_gen_core_assert.svh"

module rsag_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rsag_pkg::rsag_geom_t        geom,
  input  logic                        q_valid,
  input  rsag_pkg::rsag_item_t        q_item,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rsag_pkg::ADDR_W-1:0] out_tdata,  // source_address
  output logic                        out_tlast,  // last
  output logic                        out_tuser   // length_error
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MIR  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [rsag_pkg::DIM_W-1:0]  len_mem [rsag_pkg::BATCH];
  logic [rsag_pkg::DIM_W-1:0]  rd_r;
  logic [2:0]                  state_r;
  logic [rsag_pkg::AXIS_W-1:0] k_r;
  rsag_pkg::rsag_item_t        item_r;
  logic [rsag_pkg::ADDR_W-1:0] prod_r;
  logic [rsag_pkg::ADDR_W-1:0] acc_r;
  logic [rsag_pkg::ADDR_W-1:0] out_data_r;
  logic                        out_last_r;
  logic                        out_err_r;
  logic                        out_valid_r;
  logic                        out_free;
  logic [rsag_pkg::DIM_W-1:0]  len;
  logic [rsag_pkg::DIM_W-1:0]  seq_pos;
  logic [47:0]                 mul_full;

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // out-of-range batch index uses length 0
  assign len      = item_r.bidx_ok ? rd_r : '0;
  assign seq_pos  = item_r.pos[geom.rev_dim];
  assign mul_full = 48'(item_r.pos[k_r]) * 48'(geom.stride[k_r]);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (!q_item.is_step) len_mem[q_item.bidx] <= q_item.lval;
      rd_r <= len_mem[q_item.bidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready)               out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) state_r <= q_item.is_step ? S_MIR : S_DONE;
          k_r <= '0;
        end
        S_MIR: state_r <= S_MUL;
        S_MUL: begin
          k_r <= k_r + 1'b1;
          if (k_r == rsag_pkg::AXIS_W'(rsag_pkg::RANK - 1)) state_r <= S_ADD;
        end
        S_ADD: state_r <= S_DONE;
        S_DONE: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) item_r <= q_item;
        acc_r <= '0;
      end
      S_MIR: begin
        if (seq_pos < len) item_r.pos[geom.rev_dim] <= len - seq_pos - 16'd1;
      end
      S_MUL: begin
        prod_r <= mul_full[rsag_pkg::ADDR_W-1:0];
        if (k_r != '0) acc_r <= acc_r + prod_r;
      end
      S_ADD: acc_r <= acc_r + prod_r;
      S_DONE: begin
        if (out_free) begin
          out_data_r <= acc_r;
          out_last_r <= item_r.last;
          out_err_r  <= item_r.err;
        end
      end
      default: ;
    endcase
  end

  `RSAG_ASSERT(a_mirror_step_only, clk, rst_n, (state_r == S_MIR) |-> item_r.is_step, "load item entered mirror stage")
  `RSAG_ASSERT_NEXT(a_mul_to_add, clk, rst_n, (state_r == S_MUL && k_r == 2'd3), (state_r == S_ADD), "multiply loop did not end after last dimension")
  `RSAG_ASSERT_NEXT(a_done_emits, clk, rst_n, (state_r == S_DONE && !out_valid_r), (out_valid_r && state_r == S_IDLE), "finished result not presented")

endmodule

/* src/reverse_sequence_address_gen_core.sv */
// Step item: the back end mirrors the sequence position, then accumulates the address over
// one shared 16x32 multiplier visiting the four dimensions in turn; it pops only when idle.
// Load item: idle, then done. A 2-entry queue lets the front keep taking items.
// A register write recomputes strides, inner then outer product; no item is taken meanwhile.
// Synchronous active-low reset: registers at defaults, strides 1, counters zero,
// length table undefined until loaded (no clearing pass).
// ----------------------------------------------------------------------------
// reverse_sequence_address_gen_core
// Source-address generator for a reverse-sequence gather: register file,
// stride computation, front end, queue and back end.
// ----------------------------------------------------------------------------
module reverse_sequence_address_gen_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rsag_pkg::IN_DW-1:0]   in_tdata,   // [7:0] length_index, [23:8] length_value
  input  logic                         in_tuser,   // req_type
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rsag_pkg::ADDR_W-1:0]  out_tdata,  // source_address
  output logic                         out_tlast,  // last
  output logic                         out_tuser,  // length_error
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rsag_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [rsag_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [rsag_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  localparam logic [1:0] STR_IDLE  = 2'd0;
  localparam logic [1:0] STR_OUTER = 2'd1;
  localparam logic [1:0] STR_INNER = 2'd2;

  logic [rsag_pkg::RANK-1:0][rsag_pkg::DIM_W-1:0] dim_r;
  logic [rsag_pkg::AXIS_W-1:0]                    rev_dim_r;
  logic [rsag_pkg::AXIS_W-1:0]                    sel_dim_r;
  logic [1:0]                                     str_state_r;
  logic [rsag_pkg::ADDR_W-1:0]                    stride1_r;
  logic [rsag_pkg::ADDR_W-1:0]                    stride0_r;
  logic [2:0]                                     reg_idx;
  logic                                           wr_en;
  logic                                           wr_hit;
  logic [rsag_pkg::ADDR_W-1:0]                    inner_prod;
  logic [47:0]                                    outer_prod;
  rsag_pkg::rsag_shape_t                          shape;
  rsag_pkg::rsag_geom_t                           geom;
  logic                                           q_push;
  logic                                           q_full;
  logic                                           q_pop;
  logic                                           q_valid;
  rsag_pkg::rsag_item_t                           q_wr_item;
  rsag_pkg::rsag_item_t                           q_rd_item;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wr_hit     = wr_en && (reg_idx <= rsag_pkg::REG_SEL_DIM);

  always_comb begin
    for (int i = 0; i < rsag_pkg::RANK; i++) begin
      shape.dim[i] = (dim_r[i] == '0) ? 16'd1 : dim_r[i];
    end
    shape.rev_dim = rev_dim_r;
    shape.sel_dim = sel_dim_r;
  end

  assign inner_prod = {16'd0, shape.dim[3]} * {16'd0, shape.dim[2]};
  assign outer_prod = {16'd0, stride1_r} * {32'd0, shape.dim[1]};

  assign geom.stride[3] = 32'd1;
  assign geom.stride[2] = {16'd0, shape.dim[3]};
  assign geom.stride[1] = stride1_r;
  assign geom.stride[0] = stride0_r;
  assign geom.rev_dim   = rev_dim_r;

  always_comb begin
    unique case (reg_idx)
      rsag_pkg::REG_DIM0:    cfg_prdata = {16'd0, dim_r[0]};
      rsag_pkg::REG_DIM1:    cfg_prdata = {16'd0, dim_r[1]};
      rsag_pkg::REG_DIM2:    cfg_prdata = {16'd0, dim_r[2]};
      rsag_pkg::REG_DIM3:    cfg_prdata = {16'd0, dim_r[3]};
      rsag_pkg::REG_REV_DIM: cfg_prdata = {30'd0, rev_dim_r};
      rsag_pkg::REG_SEL_DIM: cfg_prdata = {30'd0, sel_dim_r};
      default:               cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r     <= {rsag_pkg::RANK{16'd1}};
      rev_dim_r <= '0;
      sel_dim_r <= 2'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        rsag_pkg::REG_DIM0:    dim_r[0]  <= cfg_pwdata[15:0];
        rsag_pkg::REG_DIM1:    dim_r[1]  <= cfg_pwdata[15:0];
        rsag_pkg::REG_DIM2:    dim_r[2]  <= cfg_pwdata[15:0];
        rsag_pkg::REG_DIM3:    dim_r[3]  <= cfg_pwdata[15:0];
        rsag_pkg::REG_REV_DIM: rev_dim_r <= cfg_pwdata[1:0];
        rsag_pkg::REG_SEL_DIM: sel_dim_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  // strides: middle product first, then outer product from the registered one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      str_state_r <= STR_IDLE;
      stride1_r   <= 32'd1;
      stride0_r   <= 32'd1;
    end else if (wr_hit) begin
      str_state_r <= STR_INNER;
    end else begin
      unique case (str_state_r)
        STR_INNER: begin
          stride1_r   <= inner_prod;
          str_state_r <= STR_OUTER;
        end
        STR_OUTER: begin
          stride0_r   <= outer_prod[rsag_pkg::ADDR_W-1:0];
          str_state_r <= STR_IDLE;
        end
        default: str_state_r <= STR_IDLE;
      endcase
    end
  end

  rsag_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (wr_hit),
    .busy      (str_state_r != STR_IDLE),
    .shape     (shape),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  rsag_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_item (q_rd_item)
  );

  rsag_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .q_valid    (q_valid),
    .q_item     (q_rd_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
